@@ src/cio_pkg.sv @@
// Package for the console I/O register block: port codes, widths and shared constants.
// No dependencies.
package cio_pkg;

	localparam int CramDepth = 64;
	localparam int CidxW = $clog2(CramDepth);

	localparam logic [7:0] P_JOYP  = 8'h00;
	localparam logic [7:0] P_SB    = 8'h01;
	localparam logic [7:0] P_SC    = 8'h02;
	localparam logic [7:0] P_DIV   = 8'h04;
	localparam logic [7:0] P_TIMA  = 8'h05;
	localparam logic [7:0] P_TMA   = 8'h06;
	localparam logic [7:0] P_TAC   = 8'h07;
	localparam logic [7:0] P_IF    = 8'h0F;
	localparam logic [7:0] P_SND_LO = 8'h10;
	localparam logic [7:0] P_SND_HI = 8'h26;
	localparam logic [7:0] P_LCDC  = 8'h40;
	localparam logic [7:0] P_STAT  = 8'h41;
	localparam logic [7:0] P_SCY   = 8'h42;
	localparam logic [7:0] P_SCX   = 8'h43;
	localparam logic [7:0] P_LY    = 8'h44;
	localparam logic [7:0] P_LYC   = 8'h45;
	localparam logic [7:0] P_DMA   = 8'h46;
	localparam logic [7:0] P_BGP   = 8'h47;
	localparam logic [7:0] P_OBP0  = 8'h48;
	localparam logic [7:0] P_OBP1  = 8'h49;
	localparam logic [7:0] P_WY    = 8'h4A;
	localparam logic [7:0] P_WX    = 8'h4B;
	localparam logic [7:0] P_KEY1  = 8'h4D;
	localparam logic [7:0] P_VBK   = 8'h4F;
	localparam logic [7:0] P_BOOT  = 8'h50;
	localparam logic [7:0] P_HDMA1 = 8'h51;
	localparam logic [7:0] P_HDMA2 = 8'h52;
	localparam logic [7:0] P_HDMA3 = 8'h53;
	localparam logic [7:0] P_HDMA4 = 8'h54;
	localparam logic [7:0] P_HDMA5 = 8'h55;
	localparam logic [7:0] P_BCPS  = 8'h68;
	localparam logic [7:0] P_BCPD  = 8'h69;
	localparam logic [7:0] P_OCPS  = 8'h6A;
	localparam logic [7:0] P_OCPD  = 8'h6B;
	localparam logic [7:0] P_SVBK  = 8'h70;
	localparam logic [7:0] P_IE    = 8'hFF;

	localparam logic OP_WRITE = 1'b1;
	localparam logic [0:0] REG_COLOR_MODE = 1'b0;

	function automatic logic [3:0] rate_shift(input logic [1:0] sel);
		logic [3:0] r;
		unique case (sel)
			2'd0: r = 4'd10;
			2'd1: r = 4'd4;
			2'd2: r = 4'd6;
			default: r = 4'd8;
		endcase
		return r;
	endfunction

endpackage

@@ src/console_io_register_block_top.sv @@
// Console I/O register block top level: register file, colour RAMs, APB config port.
// Depends on cio_pkg.
//
// Latency: an accepted item's result is registered in the output register.
// Throughput: one item per cycle while the output is not stalled; each colour RAM is read ahead at its next index.
// Reset: arst_n clears all control and register state to its reset value; the work RAM
// bank select to 1, timer rate shift to 10; colour RAM entries read as zero until written.
module console_io_register_block_top import cio_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       psel,
	input  logic       penable,
	input  logic       pwrite,
	input  logic [1:0] paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic       pready,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic       op,
	input  logic [7:0] port,
	input  logic [7:0] wdata,
	input  logic [3:0] joypad_directions,
	input  logic [3:0] joypad_buttons,
	input  logic [7:0] divider_high,
	input  logic [7:0] ppu_line,
	input  logic [1:0] ppu_mode,
	input  logic       lyc_match,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [7:0] rdata,
	output logic       divider_reset,
	output logic       display_reset,
	output logic       sprite_refresh,
	output logic       oam_dma_start,
	output logic       gdma_start,
	output logic [6:0] gdma_length,
	output logic       boot_rom_off
);

	// Config register: only index 0 (byte address 0) is mapped.
	logic color_mode_q;
	logic cfg_hit;
	assign pready = 1'b1;
	assign cfg_hit = (paddr[1:0] == {REG_COLOR_MODE, 1'b0});
	assign prdata = cfg_hit ? {31'd0, color_mode_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			color_mode_q <= 1'b0;
		end else if (psel && penable && pwrite && cfg_hit) begin
			color_mode_q <= pwdata[0];
		end
	end

	// Stored register file
	logic       joyp_sel_q;
	logic [7:0] tima_q, tma_q;
	logic       tac_en_q;
	logic [3:0] tac_shift_q;
	logic [7:0] if_q, ie_q, lcdc_q;
	logic [3:0] stat_en_q;
	logic [7:0] scy_q, scx_q, lyc_q, wy_q, wx_q;
	logic [7:0] dma_page_q, bgp_q;
	logic [5:0] obp0_q, obp1_q;
	logic       vbk_q;
	logic [15:0] hdma_src_q, hdma_dst_q;
	logic       hdma_act_q;
	logic [CidxW-1:0] bidx_q, oidx_q;
	logic       binc_q, oinc_q;
	logic [7:0] bcram_q [CramDepth];
	logic [7:0] ocram_q [CramDepth];
	logic [7:0] svbk_q;

	// Colour RAM read-ahead state
	logic bsel_wr, osel_wr, bwe, owe;
	logic [CidxW-1:0] bidx_d, oidx_d;
	logic [CramDepth-1:0] bvld_q, ovld_q;
	logic [7:0] brd_q, ord_q, cwd_q;
	logic bbyp_q, obyp_q, bvld_rd_q, ovld_rd_q;
	logic [7:0] bcur, ocur;

	// Output register: the result waits here while the output is stalled, and no new item is taken in meanwhile.
	logic out_valid_q;
	logic accept, advance;
	assign advance = !out_valid_q || !out_stall;
	assign in_stall = !advance;
	assign accept = in_valid && advance;
	assign out_valid = out_valid_q;

	logic wr;
	assign wr = accept && (op == OP_WRITE);

	// Colour RAMs: read the entry at the next index every cycle, so the data for the
	// current index is always in a register. Bypass a write to the entry that stays
	// selected; a valid bit per entry makes unwritten entries read as zero.
	assign bsel_wr = wr && color_mode_q && (port == P_BCPS);
	assign osel_wr = wr && color_mode_q && (port == P_OCPS);
	assign bwe = wr && color_mode_q && (port == P_BCPD);
	assign owe = wr && color_mode_q && (port == P_OCPD);

	always_comb begin
		bidx_d = bidx_q;
		if (bsel_wr) begin
			bidx_d = wdata[CidxW-1:0];
		end else if (bwe && binc_q) begin
			bidx_d = bidx_q + CidxW'(1);
		end
	end

	always_comb begin
		oidx_d = oidx_q;
		if (osel_wr) begin
			oidx_d = wdata[CidxW-1:0];
		end else if (owe && oinc_q) begin
			oidx_d = oidx_q + CidxW'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bidx_q <= '0;
			oidx_q <= '0;
			bvld_q <= '0;
			ovld_q <= '0;
			bbyp_q <= 1'b0;
			obyp_q <= 1'b0;
			bvld_rd_q <= 1'b0;
			ovld_rd_q <= 1'b0;
		end else begin
			bidx_q <= bidx_d;
			oidx_q <= oidx_d;
			if (bwe) bvld_q[bidx_q] <= 1'b1;
			if (owe) ovld_q[oidx_q] <= 1'b1;
			bbyp_q <= bwe && (bidx_d == bidx_q);
			obyp_q <= owe && (oidx_d == oidx_q);
			bvld_rd_q <= bvld_q[bidx_d];
			ovld_rd_q <= ovld_q[oidx_d];
		end
	end

	always_ff @(posedge clk) begin
		if (bwe) bcram_q[bidx_q] <= wdata;
		if (owe) ocram_q[oidx_q] <= wdata;
		brd_q <= bcram_q[bidx_d];
		ord_q <= ocram_q[oidx_d];
		cwd_q <= wdata;
	end

	assign bcur = bbyp_q ? cwd_q : (bvld_rd_q ? brd_q : 8'h00);
	assign ocur = obyp_q ? cwd_q : (ovld_rd_q ? ord_q : 8'h00);

	// Read mux over stored fields and live status
	logic [7:0] rd;
	always_comb begin
		rd = 8'hFF;
		if (port >= P_SND_LO && port <= P_SND_HI) begin
			rd = 8'h00;
		end else begin
			unique case (port)
				P_JOYP: rd = joyp_sel_q ? (8'hE0 | {4'd0, joypad_directions})
				                        : (8'hD0 | {4'd0, joypad_buttons});
				P_SB, P_SC, P_KEY1: rd = 8'h00;
				P_DIV:  rd = divider_high;
				P_TIMA: rd = tima_q;
				P_IF:   rd = if_q;
				P_LCDC: rd = lcdc_q;
				P_STAT: rd = {1'b0, stat_en_q, lyc_match, ppu_mode};
				P_SCY:  rd = scy_q;
				P_SCX:  rd = scx_q;
				P_LY:   rd = ppu_line;
				P_DMA:  rd = dma_page_q;
				P_BGP:  rd = bgp_q;
				P_OBP0: rd = {obp0_q, 2'b00};
				P_OBP1: rd = {obp1_q, 2'b00};
				P_WY:   rd = wy_q;
				P_WX:   rd = wx_q;
				P_VBK:  rd = {7'd0, vbk_q};
				P_HDMA5: if (color_mode_q) rd = hdma_act_q ? 8'h00 : 8'hFF;
				P_BCPS: if (color_mode_q) rd = {binc_q, 1'b0, bidx_q};
				P_OCPS: if (color_mode_q) rd = {oinc_q, 1'b0, oidx_q};
				P_BCPD: if (color_mode_q) rd = bcur;
				P_OCPD: if (color_mode_q) rd = ocur;
				P_SVBK: if (color_mode_q) rd = svbk_q;
				P_IE:   rd = ie_q;
				default: rd = 8'hFF;
			endcase
		end
	end

	// Register updates on write items
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			joyp_sel_q <= 1'b0; tima_q <= '0; tma_q <= '0; tac_en_q <= 1'b0;
			tac_shift_q <= 4'd10; if_q <= '0; ie_q <= '0; lcdc_q <= '0;
			stat_en_q <= '0; scy_q <= '0; scx_q <= '0; lyc_q <= '0; wy_q <= '0;
			wx_q <= '0; dma_page_q <= '0; bgp_q <= '0; obp0_q <= '0; obp1_q <= '0;
			vbk_q <= 1'b0; hdma_src_q <= '0; hdma_dst_q <= '0; hdma_act_q <= 1'b0;
			binc_q <= 1'b0; oinc_q <= 1'b0;
			svbk_q <= 8'd1;
		end else if (wr) begin
			unique case (port)
				P_JOYP: joyp_sel_q <= wdata[5];
				P_TIMA: tima_q <= wdata;
				P_TMA:  tma_q <= wdata;
				P_TAC: begin
					tac_en_q <= wdata[2];
					tac_shift_q <= rate_shift(wdata[1:0]);
				end
				P_IF:   if_q <= wdata;
				P_LCDC: lcdc_q <= wdata;
				P_STAT: stat_en_q <= wdata[6:3];
				P_SCY:  scy_q <= wdata;
				P_SCX:  scx_q <= wdata;
				P_LYC:  lyc_q <= wdata;
				P_DMA:  dma_page_q <= wdata;
				P_BGP:  bgp_q <= wdata;
				P_OBP0: obp0_q <= wdata[7:2];
				P_OBP1: obp1_q <= wdata[7:2];
				P_WY:   wy_q <= wdata;
				P_WX:   wx_q <= wdata;
				P_VBK:  vbk_q <= wdata[0];
				P_HDMA1: if (color_mode_q) hdma_src_q[15:8] <= wdata;
				P_HDMA2: if (color_mode_q) hdma_src_q[7:0] <= {wdata[7:4], 4'd0};
				P_HDMA3: if (color_mode_q) hdma_dst_q[15:8] <= wdata;
				P_HDMA4: if (color_mode_q) hdma_dst_q[7:0] <= {wdata[7:4], 4'd0};
				P_HDMA5: if (color_mode_q && wdata[7]) hdma_act_q <= 1'b1;
				P_BCPS: if (color_mode_q) binc_q <= wdata[7];
				P_OCPS: if (color_mode_q) oinc_q <= wdata[7];
				P_SVBK: if (color_mode_q) svbk_q <= (wdata == 8'd0) ? 8'd1 : wdata;
				P_IE:   ie_q <= wdata;
				default: ;
			endcase
		end
	end

	// Result register
	logic gdma_hit;
	assign gdma_hit = (port == P_HDMA5) && color_mode_q && !wdata[7];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			rdata          <= (op == OP_WRITE) ? 8'hFF : rd;
			divider_reset  <= wr && port == P_DIV;
			display_reset  <= wr && port == P_LCDC && !wdata[7];
			sprite_refresh <= wr && port == P_LCDC && (lcdc_q[1] != wdata[1]);
			oam_dma_start  <= wr && port == P_DMA;
			gdma_start     <= wr && gdma_hit;
			gdma_length    <= (wr && gdma_hit) ? wdata[6:0] : 7'd0;
			boot_rom_off   <= wr && port == P_BOOT;
		end
	end

endmodule

@@ test/tb_console_io_register_block_top.sv @@
// Testbench for the console I/O register block: directed table, then random bus accesses.
// Depends on cio_pkg and console_io_register_block_top; predicts every result in place.
module tb_console_io_register_block_top import cio_pkg::*; ();

	typedef struct packed {
		logic [7:0] rdata;
		logic       divider_reset;
		logic       display_reset;
		logic       sprite_refresh;
		logic       oam_dma_start;
		logic       gdma_start;
		logic [6:0] gdma_length;
		logic       boot_rom_off;
	} bus_result_t;

	typedef struct packed {
		logic       op;
		logic [7:0] port;
		logic [7:0] wdata;
		logic [3:0] dirs;
		logic [3:0] btns;
		logic [7:0] div_hi;
		logic [7:0] line;
		logic [1:0] mode;
		logic       lyc;
	} bus_access_t;

	// directed row: access, whether an expected rdata is given, and its value
	typedef struct packed {
		bus_access_t acc;
		logic        has_rdata;
		logic [7:0]  rdata;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [1:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic in_valid = 1'b0;
	logic in_stall;
	logic op = 1'b0;
	logic [7:0] port = '0, wdata = '0, divider_high = '0, ppu_line = '0;
	logic [3:0] joypad_directions = '0, joypad_buttons = '0;
	logic [1:0] ppu_mode = '0;
	logic lyc_match = 1'b0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [7:0] rdata;
	logic divider_reset, display_reset, sprite_refresh, oam_dma_start, gdma_start;
	logic [6:0] gdma_length;
	logic boot_rom_off;

	console_io_register_block_top uut (.*);

	always #5 clk = ~clk;

	// predictor state
	logic        m_color_mode;
	logic        m_joyp_sel;
	logic [7:0]  m_tima, m_tma, m_if, m_ie, m_lcdc, m_dma, m_bgp;
	logic        m_tac_en;
	logic [3:0]  m_tac_shift, m_stat_en;
	logic [7:0]  m_scroll [5];
	logic [5:0]  m_obp [2];
	logic        m_vbk, m_hdma_active;
	logic [15:0] m_hdma [2];
	logic [5:0]  m_cidx [2];
	logic        m_cinc [2];
	logic [7:0]  m_cram [2][64];
	logic [7:0]  m_svbk;

	bus_result_t expected_results [$];
	int  mismatch_count = 0;
	int  idle_cycles = 0;
	bit  stim_done = 1'b0;

	task automatic reset_predictor();
		m_color_mode = 0; m_joyp_sel = 0; m_tima = 0; m_tma = 0; m_if = 0; m_ie = 0;
		m_lcdc = 0; m_dma = 0; m_bgp = 0; m_tac_en = 0; m_tac_shift = 4'd10; m_stat_en = 0;
		foreach (m_scroll[i]) m_scroll[i] = 0;
		for (int w = 0; w < 2; w++) begin
			m_obp[w] = 0; m_hdma[w] = 0; m_cidx[w] = 0; m_cinc[w] = 0;
			for (int j = 0; j < 64; j++) m_cram[w][j] = 0;
		end
		m_vbk = 0; m_hdma_active = 0; m_svbk = 8'd1;
	endtask

	function automatic logic [7:0] read_port(bus_access_t a);
		logic w;
		w = (a.port == P_OCPS) || (a.port == P_OCPD);
		if (a.port >= P_SND_LO && a.port <= P_SND_HI) return 8'h00;
		case (a.port)
			P_JOYP: return m_joyp_sel ? {4'hE, a.dirs} : {4'hD, a.btns};
			P_SB, P_SC, P_KEY1: return 8'h00;
			P_DIV:  return a.div_hi;
			P_TIMA: return m_tima;
			P_IF:   return m_if;
			P_LCDC: return m_lcdc;
			P_STAT: return {1'b0, m_stat_en, a.lyc, a.mode};
			P_SCY:  return m_scroll[0];
			P_SCX:  return m_scroll[1];
			P_LY:   return a.line;
			P_DMA:  return m_dma;
			P_BGP:  return m_bgp;
			P_OBP0: return {m_obp[0], 2'b00};
			P_OBP1: return {m_obp[1], 2'b00};
			P_WY:   return m_scroll[3];
			P_WX:   return m_scroll[4];
			P_VBK:  return {7'd0, m_vbk};
			P_HDMA5: if (m_color_mode) return m_hdma_active ? 8'h00 : 8'hFF;
			P_BCPS, P_OCPS: if (m_color_mode) return {m_cinc[w], 1'b0, m_cidx[w]};
			P_BCPD, P_OCPD: if (m_color_mode) return m_cram[w][m_cidx[w]];
			P_SVBK: if (m_color_mode) return m_svbk;
			P_IE:   return m_ie;
			default: ;
		endcase
		return 8'hFF;
	endfunction

	// apply one access to the predictor state and return what the block should emit
	function automatic bus_result_t predict_access(bus_access_t a);
		bus_result_t r;
		logic w;
		logic [7:0] v;
		r = '0;
		r.rdata = 8'hFF;
		v = a.wdata;
		w = (a.port == P_HDMA3) || (a.port == P_HDMA4) || (a.port == P_OCPS) ||
			(a.port == P_OCPD);
		if (a.op != OP_WRITE) begin
			r.rdata = read_port(a);
			return r;
		end
		case (a.port)
			P_JOYP: m_joyp_sel = v[5];
			P_DIV:  r.divider_reset = 1'b1;
			P_TIMA: m_tima = v;
			P_TMA:  m_tma = v;
			P_TAC: begin
				m_tac_en = v[2];
				m_tac_shift = (v[1:0] == 2'd0) ? 4'd10 : (v[1:0] == 2'd1) ? 4'd4 :
					(v[1:0] == 2'd2) ? 4'd6 : 4'd8;
			end
			P_IF:   m_if = v;
			P_LCDC: begin
				r.sprite_refresh = m_lcdc[1] ^ v[1];
				r.display_reset = ~v[7];
				m_lcdc = v;
			end
			P_STAT: m_stat_en = v[6:3];
			P_SCY:  m_scroll[0] = v;
			P_SCX:  m_scroll[1] = v;
			P_LYC:  m_scroll[2] = v;
			P_DMA: begin
				m_dma = v;
				r.oam_dma_start = 1'b1;
			end
			P_BGP:  m_bgp = v;
			P_OBP0: m_obp[0] = v[7:2];
			P_OBP1: m_obp[1] = v[7:2];
			P_WY:   m_scroll[3] = v;
			P_WX:   m_scroll[4] = v;
			P_VBK:  m_vbk = v[0];
			P_BOOT: r.boot_rom_off = 1'b1;
			P_HDMA1, P_HDMA3: if (m_color_mode) m_hdma[w][15:8] = v;
			P_HDMA2, P_HDMA4: if (m_color_mode) m_hdma[w][7:0] = v & 8'hF0;
			P_HDMA5: if (m_color_mode) begin
				if (v[7]) m_hdma_active = 1'b1;
				else begin
					r.gdma_start = 1'b1;
					r.gdma_length = v[6:0];
				end
			end
			P_BCPS, P_OCPS: if (m_color_mode) begin
				m_cidx[w] = v[5:0];
				m_cinc[w] = v[7];
			end
			P_BCPD, P_OCPD: if (m_color_mode) begin
				m_cram[w][m_cidx[w]] = v;
				if (m_cinc[w]) m_cidx[w] = m_cidx[w] + 6'd1;
			end
			P_SVBK: if (m_color_mode) m_svbk = (v == 8'h00) ? 8'h01 : v;
			P_IE:   m_ie = v;
			default: ;
		endcase
		return r;
	endfunction

	task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] exp);
		$display("MISMATCH %s: got %0h, expected %0h at %0t", what, got, exp, $realtime);
		mismatch_count++;
	endtask

	// Receiver: stall at random, with a density that changes now and then; compare results
	int stall_mode = 0;
	always @(posedge clk) begin
		bus_result_t e;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (expected_results.size() == 0) begin
					report_mismatch("unexpected item", rdata, 8'h00);
				end else begin
					e = expected_results.pop_front();
					if (rdata !== e.rdata) report_mismatch("rdata", rdata, e.rdata);
					if (divider_reset !== e.divider_reset)
						report_mismatch("divider_reset", 8'(divider_reset),
							8'(e.divider_reset));
					if (display_reset !== e.display_reset)
						report_mismatch("display_reset", 8'(display_reset),
							8'(e.display_reset));
					if (sprite_refresh !== e.sprite_refresh)
						report_mismatch("sprite_refresh", 8'(sprite_refresh),
							8'(e.sprite_refresh));
					if (oam_dma_start !== e.oam_dma_start)
						report_mismatch("oam_dma_start", 8'(oam_dma_start),
							8'(e.oam_dma_start));
					if (gdma_start !== e.gdma_start)
						report_mismatch("gdma_start", 8'(gdma_start), 8'(e.gdma_start));
					if (gdma_length !== e.gdma_length)
						report_mismatch("gdma_length", 8'(gdma_length), 8'(e.gdma_length));
					if (boot_rom_off !== e.boot_rom_off)
						report_mismatch("boot_rom_off", 8'(boot_rom_off),
							8'(e.boot_rom_off));
				end
			end
			if ($urandom_range(0, 63) == 0) stall_mode <= $urandom_range(0, 3);
			case (stall_mode)
				0: out_stall <= 1'b0;
				1: out_stall <= ($urandom_range(0, 3) == 0);
				2: out_stall <= ($urandom_range(0, 1) == 0);
				default: out_stall <= ($urandom_range(0, 7) != 0);
			endcase
		end
	end

	// Watchdog: count cycles in which neither channel moves an item
	always @(posedge clk) begin
		if (arst_n) begin
			if ((in_valid && !in_stall) || (out_valid && !out_stall) || psel) idle_cycles <= 0;
			else if (stim_done && expected_results.size() == 0) idle_cycles <= 0;
			else idle_cycles <= idle_cycles + 1;
			if (idle_cycles >= 2000) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	int burst_left = 0;

	// Drive one item and hold it until accepted; bursts and gaps come from burst_left
	task automatic send_access(bus_access_t a);
		if (burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(posedge clk);
			burst_left = $urandom_range(1, 20);
		end
		burst_left--;
		in_valid <= 1'b1;
		op <= a.op; port <= a.port; wdata <= a.wdata;
		joypad_directions <= a.dirs; joypad_buttons <= a.btns;
		divider_high <= a.div_hi; ppu_line <= a.line; ppu_mode <= a.mode;
		lyc_match <= a.lyc;
		do @(posedge clk); while (in_stall);
		expected_results.push_back(predict_access(a));
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		@(posedge clk);
		while (expected_results.size() != 0) @(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	// Write the colour mode register over APB while the block is idle
	task automatic set_color_mode(logic value);
		drain();
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {REG_COLOR_MODE, 1'b0}; pwdata <= {31'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		m_color_mode = value;
		@(posedge clk);
	endtask

	function automatic bus_access_t make_access(logic o, logic [7:0] p, logic [7:0] d);
		bus_access_t a;
		a.op = o; a.port = p; a.wdata = d;
		a.dirs = 4'($urandom); a.btns = 4'($urandom); a.div_hi = 8'($urandom);
		a.line = 8'($urandom_range(0, 153)); a.mode = 2'($urandom); a.lyc = 1'($urandom);
		return a;
	endfunction

	// Random port drawn mostly from mapped registers, with some of the whole space
	function automatic logic [7:0] pick_port();
		logic [7:0] mapped [] = '{P_JOYP, P_SB, P_SC, P_DIV, P_TIMA, P_TMA, P_TAC, P_IF,
			P_SND_LO, P_SND_HI, P_LCDC, P_STAT, P_SCY, P_SCX, P_LY, P_LYC, P_DMA, P_BGP,
			P_OBP0, P_OBP1, P_WY, P_WX, P_KEY1, P_VBK, P_BOOT, P_HDMA1, P_HDMA2, P_HDMA3,
			P_HDMA4, P_HDMA5, P_BCPS, P_BCPD, P_OCPS, P_OCPD, P_SVBK, P_IE};
		if ($urandom_range(0, 4) == 0) return 8'($urandom);
		return mapped[$urandom_range(0, mapped.size() - 1)];
	endfunction

	task automatic random_phase(int n);
		bus_access_t a;
		logic [7:0] p;
		int k;
		for (int i = 0; i < n; i++) begin
			k = $urandom_range(0, 9);
			if (k < 2) begin
				// colour RAM sequence: set index with auto-increment, write a run, set a new index, read data and index
				p = $urandom_range(0, 1) ? P_OCPS : P_BCPS;
				send_access(make_access(OP_WRITE, p, {1'b1, 1'b0, 6'($urandom)}));
				repeat ($urandom_range(1, 8))
					send_access(make_access(OP_WRITE, p + 8'd1, 8'($urandom)));
				send_access(make_access(OP_WRITE, p, {2'b00, 6'($urandom)}));
				send_access(make_access(1'b0, p + 8'd1, 8'($urandom)));
				send_access(make_access(1'b0, p, 8'($urandom)));
			end else begin
				send_access(make_access(1'($urandom), pick_port(), 8'($urandom)));
			end
		end
	endtask

	dir_row_t directed [$];

	task automatic add_row(logic o, logic [7:0] p, logic [7:0] d, logic chk, logic [7:0] r);
		dir_row_t row;
		row.acc = make_access(o, p, d);
		row.has_rdata = chk;
		row.rdata = r;
		directed.push_back(row);
	endtask

	initial begin
		bus_result_t e;
		reset_predictor();
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: reset values, extremes, pulses, then colour ports enabled
		add_row(1'b0, P_TIMA, 8'h00, 1'b1, 8'h00);
		add_row(1'b0, P_SB,   8'h00, 1'b1, 8'h00);
		add_row(1'b0, P_SND_HI, 8'h00, 1'b1, 8'h00);
		add_row(1'b0, 8'h03,  8'h00, 1'b1, 8'hFF);
		add_row(1'b0, P_TMA,  8'h00, 1'b1, 8'hFF);
		add_row(1'b0, P_BCPS, 8'h00, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_SVBK, 8'h07, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_JOYP, 8'hFF, 1'b1, 8'hFF);
		add_row(1'b0, P_JOYP, 8'h00, 1'b0, 8'h00);
		add_row(OP_WRITE, P_DIV,  8'h00, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_LCDC, 8'h02, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_LCDC, 8'hFF, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_DMA,  8'hC0, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_BOOT, 8'h01, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_OBP0, 8'hFF, 1'b1, 8'hFF);
		add_row(1'b0, P_OBP0, 8'h00, 1'b1, 8'hFC);
		add_row(OP_WRITE, P_TAC,  8'h07, 1'b1, 8'hFF);
		add_row(1'b0, P_STAT, 8'h00, 1'b0, 8'h00);
		add_row(1'b0, P_IE,   8'h00, 1'b1, 8'h00);
		foreach (directed[i]) begin
			send_access(directed[i].acc);
			if (directed[i].has_rdata) begin
				e = expected_results.pop_back();
				e.rdata = directed[i].rdata;
				expected_results.push_back(e);
			end
		end

		set_color_mode(1'b1);
		directed.delete();
		add_row(1'b0, P_SVBK, 8'h00, 1'b1, 8'h01);
		add_row(OP_WRITE, P_SVBK, 8'h00, 1'b1, 8'hFF);
		add_row(1'b0, P_HDMA5, 8'h00, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_HDMA5, 8'h7F, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_BCPS, 8'hBF, 1'b1, 8'hFF);
		add_row(OP_WRITE, P_BCPD, 8'h5A, 1'b1, 8'hFF);
		add_row(1'b0, P_BCPS, 8'h00, 1'b1, 8'h80);
		add_row(OP_WRITE, P_HDMA5, 8'h80, 1'b1, 8'hFF);
		add_row(1'b0, P_HDMA5, 8'h00, 1'b1, 8'h00);
		foreach (directed[i]) begin
			send_access(directed[i].acc);
			if (directed[i].has_rdata) begin
				e = expected_results.pop_back();
				e.rdata = directed[i].rdata;
				expected_results.push_back(e);
			end
		end

		// Random phases through both colour mode settings
		random_phase(200);
		set_color_mode(1'b0);
		random_phase(180);
		// hold off until every expected item has come back
		drain();
		set_color_mode(1'b1);
		random_phase(240);
		set_color_mode(1'b0);
		random_phase(60);
		set_color_mode(1'b1);
		random_phase(90);

		drain();
		stim_done = 1'b1;
		repeat (5) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

@@ filelist.f @@
src/cio_pkg.sv
src/console_io_register_block_top.sv
test/tb_console_io_register_block_top.sv
